[rtl/dmc_pkg.sv]
`timescale 1ns / 1ps
// Package for the direct-mapped cache lookup core.
// Holds the configuration width, its reset value and the result status codes.
package dmc_pkg;

  // Width and reset value of the line count register.
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_RESET = 256;

  // Result status codes.
  localparam int unsigned STATUS_W = 2;
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT        = 2'd0,
    ST_MISS_EMPTY = 2'd1,
    ST_MISS_EVICT = 2'd2
  } status_e;

endpackage

[rtl/dmc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the cache lookup core.
// Depends on dmc_pkg for the status width.
interface dmc_req_if #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned DATA_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic        [ADDR_BITS-1:0] address;
  logic signed [DATA_BITS-1:0] mem_data;

  modport source (output valid, output address, output mem_data, input ready);
  modport sink   (input valid, input address, input mem_data, output ready);
endinterface

interface dmc_rsp_if #(
  parameter int unsigned IDX_BITS  = 8,
  parameter int unsigned DATA_BITS = 32
);
  import dmc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic        [STATUS_W-1:0]  status;
  logic        [IDX_BITS-1:0]  line_index;
  logic signed [DATA_BITS-1:0] read_data;

  modport source (output valid, output status, output line_index, output read_data,
                  input ready);
  modport sink   (input valid, input status, input line_index, input read_data,
                  output ready);
endinterface

[rtl/dmc_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module dmc_ram #(
  parameter int unsigned WIDTH = 49,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dmc_rem_unit.sv]
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on dmc_pkg for the divisor width.
module dmc_rem_unit #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ADDR_BITS-1:0]          dividend_i,
  input  logic [dmc_pkg::CFG_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [dmc_pkg::CFG_W-1:0]     rem_o
);
  import dmc_pkg::*;

  localparam int unsigned CNT_W = $clog2(ADDR_BITS + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ADDR_BITS-1:0] num_q, num_d;
  logic [CFG_W-1:0]     div_q, div_d;
  logic [CFG_W-1:0]     rem_q, rem_d;
  logic [CFG_W:0]       trial;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  assign trial = {rem_q, num_q[ADDR_BITS-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ADDR_BITS);
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = CFG_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = CFG_W'(trial);
      end
      num_d = num_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[rtl/direct_mapped_cache_lookup_core.sv]
`timescale 1ns / 1ps
// Top level of the direct-mapped cache lookup core.
// Depends on dmc_pkg, dmc_if, dmc_ram and dmc_rem_unit.
//
//  Port        Dir  Handshake     Carries
//  req_i       in   valid/ready   address, mem_data
//  rsp_o       out  valid/ready   status, line_index, read_data
//  cfg_we_i    in   write enable  cfg_wdata_i = line count
//
// A request passes through these steps: the core accepts it, the
// bit-serial remainder unit forms the line index, the line RAM is read,
// hit or miss is resolved and a miss writes the new entry into the line,
// and the response register is loaded. After reset the core sweeps the
// line RAM once to mark every line empty; requests wait during it, while
// configuration writes are taken as usual. A new request may be accepted
// while the previous response still waits on rsp_o; the core only stalls
// when its next response is ready and the output register is still full.
module direct_mapped_cache_lookup_core #(
  parameter int unsigned MAX_LINES = 256,
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dmc_pkg::CFG_W-1:0] cfg_wdata_i,
  dmc_req_if.sink                   req_i,
  dmc_rsp_if.source                 rsp_o
);
  import dmc_pkg::*;

  localparam int unsigned IDX_W   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned ENTRY_W = 1 + ADDR_BITS + DATA_BITS;

  // Sequencer states.
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [IDX_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic [CFG_W-1:0]     cfg_q;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [DATA_BITS-1:0] word_q, word_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [DATA_BITS-1:0] res_data_q, res_data_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;
  logic [DATA_BITS-1:0] out_data_q, out_data_d;

  logic                 req_fire;
  logic                 push;
  logic [CFG_W-1:0]     eff_lines;
  logic                 rem_done;
  logic [CFG_W-1:0]     rem;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic                 line_valid;
  logic [ADDR_BITS-1:0] line_tag;
  logic [DATA_BITS-1:0] line_word;
  logic                 hit;

  // The line count register. Zero acts as one line, and a count above the
  // line storage acts as the full storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_W'(CFG_RESET);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      eff_lines = CFG_W'(1);
    end else if (32'(cfg_q) > MAX_LINES) begin
      eff_lines = CFG_W'(MAX_LINES);
    end else begin
      eff_lines = cfg_q;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // The index is address modulo the effective line count, worked out one
  // address bit per cycle.
  dmc_rem_unit #(
    .ADDR_BITS (ADDR_BITS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_fire),
    .dividend_i (req_i.address),
    .divisor_i  (eff_lines),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // Each line entry holds a valid bit, the full address as tag, and the word.
  dmc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LINES),
    .AW    (IDX_W)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (IDX_W'(rem)),
    .rdata_o (ram_rdata)
  );

  assign line_valid = ram_rdata[ENTRY_W-1];
  assign line_tag   = ram_rdata[ADDR_BITS+DATA_BITS-1:DATA_BITS];
  assign line_word  = ram_rdata[DATA_BITS-1:0];
  assign hit        = line_valid && (line_tag == addr_q);

  assign ram_re    = (state_q == S_DIV) && rem_done;
  assign ram_we    = (state_q == S_CLR) || ((state_q == S_LOOK) && !hit);
  assign ram_waddr = (state_q == S_CLR) ? clr_cnt_q : idx_q;
  assign ram_wdata = (state_q == S_CLR) ? '0 : {1'b1, addr_q, word_q};

  // The output register frees up when it is empty or being taken this cycle.
  assign push = (state_q == S_PUSH) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    addr_d       = addr_q;
    word_d       = word_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    case (state_q)
      S_CLR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IDX_W'(MAX_LINES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          addr_d  = req_i.address;
          word_d  = req_i.mem_data;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          idx_d   = IDX_W'(rem);
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        // On a hit the stored word wins; on a miss the line takes the new word.
        if (hit) begin
          res_status_d = ST_HIT;
          res_data_d   = line_word;
        end else if (line_valid) begin
          res_status_d = ST_MISS_EVICT;
          res_data_d   = word_q;
        end else begin
          res_status_d = ST_MISS_EMPTY;
          res_data_d   = word_q;
        end
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (push) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d  = rsp_valid_q;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_data_d   = out_data_q;
    if (push) begin
      rsp_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_idx_d    = idx_q;
      out_data_d   = res_data_q;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    word_q       <= word_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_data_q   <= out_data_d;
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.line_index = out_idx_q;
  assign rsp_o.read_data  = out_data_q;

endmodule
